/* rtl/core/gasa_pkg.sv */
// Shared constants for the glyph atlas shelf allocator.
// Field widths, result kind codes and default geometry; no dependencies.
package gasa_pkg;

  localparam int unsigned DEF_RING_DEPTH   = 32;
  localparam int unsigned DEF_ATLAS_WIDTH  = 512;
  localparam int unsigned DEF_ATLAS_HEIGHT = 512;

  // one-pixel border on each side of a glyph box
  localparam int unsigned BORDER_TOTAL = 2;

  localparam int unsigned GLYPH_ID_W = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_EVICTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLACED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSHED = 2'd2;

  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

endpackage

/* rtl/core/glyph_atlas_shelf_allocator_top.sv */
// Glyph atlas shelf allocator: shelf packing of bordered glyph boxes plus a ring of placed glyphs.
// Depends on gasa_pkg and gasa_ram (glyph id and stored row per ring slot).
//
// A placement runs ROW, ATL, TCHK and FCHK, then PLACE, with an RD/EV walk for a wrap, a taller
//   shelf or a full ring; each retire does one read of the entry RAM and then one compare.
// A flush scans the ring slots in turn, reads and evicts each live one, then emits a flushed marker.
// One request in flight; a new beat is taken as soon as the last result sits in the output
// register. Reset clears pointers, cursor, shelf and all live bits; the RAM is not cleared.
module glyph_atlas_shelf_allocator_top #(
  parameter int unsigned RING_DEPTH   = gasa_pkg::DEF_RING_DEPTH,
  parameter int unsigned ATLAS_WIDTH  = gasa_pkg::DEF_ATLAS_WIDTH,
  parameter int unsigned ATLAS_HEIGHT = gasa_pkg::DEF_ATLAS_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [gasa_pkg::GLYPH_ID_W-1:0]  glyph_id_i,
  input  logic [gasa_pkg::DIM_W-1:0]       glyph_width_i,
  input  logic [gasa_pkg::DIM_W-1:0]       glyph_height_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gasa_pkg::KIND_W-1:0]      kind_o,
  output logic [gasa_pkg::SLOT_W-1:0]      slot_o,
  output logic [gasa_pkg::GLYPH_ID_W-1:0]  out_glyph_id_o,
  output logic [gasa_pkg::DIM_W-1:0]       atlas_x_o,
  output logic [gasa_pkg::DIM_W-1:0]       atlas_y_o,
  output logic                             last_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned MAX_WH = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
  localparam int unsigned MAX_DIM = (MAX_WH > 512) ? MAX_WH : 512;
  // coordinates plus one box height never overflow this
  localparam int unsigned CW = $clog2(MAX_DIM) + 2;
  localparam int unsigned GW = gasa_pkg::GLYPH_ID_W;
  localparam int unsigned RW = GW + CW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ROW   = 4'd1;
  localparam logic [3:0] ST_ATL   = 4'd2;
  localparam logic [3:0] ST_TCHK  = 4'd3;
  localparam logic [3:0] ST_FCHK  = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_EV    = 4'd6;
  localparam logic [3:0] ST_PLACE = 4'd7;
  localparam logic [3:0] ST_FSCAN = 4'd8;
  localparam logic [3:0] ST_FEV   = 4'd9;
  localparam logic [3:0] ST_FDONE = 4'd10;

  localparam logic [1:0] MODE_WRAP = 2'd0;
  localparam logic [1:0] MODE_TALL = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [1:0]            mode_q, mode_d;
  logic [PW-1:0]         oldest_q, oldest_d;
  logic [PW-1:0]         next_q, next_d;
  logic [PW-1:0]         scan_q, scan_d;
  logic [CW-1:0]         cx_q, cx_d;
  logic [CW-1:0]         cy_q, cy_d;
  logic [CW-1:0]         sh_q, sh_d;
  logic [CW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         hi_q, hi_d;
  logic [RING_DEPTH-1:0] live_q, live_d;

  // request beat
  logic                  req_q, req_d;
  logic [GW-1:0]         gid_q, gid_d;
  logic [CW-1:0]         bw_q, bw_d;
  logic [CW-1:0]         bh_q, bh_d;

  // output register
  logic                                 out_valid_q;
  logic [gasa_pkg::KIND_W-1:0]          kind_q;
  logic [gasa_pkg::SLOT_W-1:0]          slot_q;
  logic [GW-1:0]                        ogid_q;
  logic [gasa_pkg::DIM_W-1:0]           ax_q;
  logic [gasa_pkg::DIM_W-1:0]           ay_q;
  logic                                 last_q;

  logic                                 out_free;
  logic                                 emit;
  logic [gasa_pkg::KIND_W-1:0]          emit_kind;
  logic [PW-1:0]                        emit_slot;
  logic [GW-1:0]                        emit_gid;
  logic [CW-1:0]                        emit_x;
  logic [CW-1:0]                        emit_y;
  logic                                 emit_last;

  logic                  ram_we;
  logic [RW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [PW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [GW-1:0]         rd_gid;
  logic [CW-1:0]         rd_row;
  logic                  walk_hit;
  logic                  not_empty;

  gasa_ram #(
    .WIDTH (RW),
    .DEPTH (RING_DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (next_q),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign rd_gid    = ram_rdata[RW-1:CW];
  assign rd_row    = ram_rdata[CW-1:0];
  assign ram_wdata = {gid_q, cy_q + CW'(1)};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign not_empty = (oldest_q != next_q);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    unique case (mode_q)
      MODE_WRAP: walk_hit = not_empty && (rd_row != '0);
      MODE_TALL: walk_hit = not_empty && (rd_row >= lo_q) && (rd_row < hi_q);
      MODE_FULL: walk_hit = 1'b1;
      default:   walk_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    oldest_d  = oldest_q;
    next_d    = next_q;
    scan_d    = scan_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    sh_d      = sh_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    live_d    = live_q;
    req_d     = req_q;
    gid_d     = gid_q;
    bw_d      = bw_q;
    bh_d      = bh_q;
    emit      = 1'b0;
    emit_kind = gasa_pkg::KIND_EVICTED;
    emit_slot = oldest_q;
    emit_gid  = rd_gid;
    emit_x    = '0;
    emit_y    = '0;
    emit_last = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = oldest_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = req_type_i;
          gid_d  = glyph_id_i;
          bw_d   = CW'(glyph_width_i) + CW'(gasa_pkg::BORDER_TOTAL);
          bh_d   = CW'(glyph_height_i) + CW'(gasa_pkg::BORDER_TOTAL);
          scan_d = '0;
          state_d = (req_type_i == gasa_pkg::REQ_FLUSH) ? ST_FSCAN : ST_ROW;
        end
      end
      ST_ROW: begin
        if (bw_q + cx_q > CW'(ATLAS_WIDTH)) begin
          cx_d = '0;
          cy_d = cy_q + sh_q;
          sh_d = '0;
        end
        state_d = ST_ATL;
      end
      ST_ATL: begin
        if (bh_q + cy_q > CW'(ATLAS_HEIGHT)) begin
          cx_d    = '0;
          cy_d    = '0;
          sh_d    = '0;
          mode_d  = MODE_WRAP;
          state_d = ST_RD;
        end else begin
          state_d = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (sh_q <= bh_q) begin
          lo_d    = cy_q + sh_q;
          hi_d    = cy_q + bh_q;
          mode_d  = MODE_TALL;
          state_d = ST_RD;
        end else begin
          state_d = ST_FCHK;
        end
      end
      ST_FCHK: begin
        if (oldest_q == ptr_inc(next_q)) begin
          mode_d  = MODE_FULL;
          state_d = ST_RD;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_EV;
      end
      ST_EV: begin
        if (walk_hit) begin
          if (!live_q[oldest_q] || out_free) begin
            emit              = live_q[oldest_q];
            live_d[oldest_q]  = 1'b0;
            oldest_d          = ptr_inc(oldest_q);
            state_d           = (mode_q == MODE_FULL) ? ST_PLACE : ST_RD;
          end
        end else if (mode_q == MODE_WRAP) begin
          state_d = ST_TCHK;
        end else begin
          sh_d    = bh_q;
          state_d = ST_FCHK;
        end
      end
      ST_PLACE: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_kind      = gasa_pkg::KIND_PLACED;
          emit_slot      = next_q;
          emit_gid       = gid_q;
          emit_x         = cx_q;
          emit_y         = cy_q;
          emit_last      = 1'b1;
          ram_we         = 1'b1;
          live_d[next_q] = 1'b1;
          cx_d           = cx_q + bw_q;
          next_d         = ptr_inc(next_q);
          state_d        = ST_IDLE;
        end
      end
      ST_FSCAN: begin
        if (live_q[scan_q]) begin
          ram_re    = 1'b1;
          ram_raddr = scan_q;
          state_d   = ST_FEV;
        end else if (scan_q == PTR_LAST) begin
          state_d = ST_FDONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FEV: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_slot      = scan_q;
          live_d[scan_q] = 1'b0;
          if (scan_q == PTR_LAST) begin
            state_d = ST_FDONE;
          end else begin
            scan_d  = scan_q + 1'b1;
            state_d = ST_FSCAN;
          end
        end
      end
      ST_FDONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = gasa_pkg::KIND_FLUSHED;
          emit_slot = '0;
          emit_gid  = '0;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_WRAP;
      oldest_q    <= '0;
      next_q      <= '0;
      scan_q      <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      sh_q        <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      oldest_q <= oldest_d;
      next_q   <= next_d;
      scan_q   <= scan_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      sh_q     <= sh_d;
      live_q   <= live_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    req_q <= req_d;
    gid_q <= gid_d;
    bw_q  <= bw_d;
    bh_q  <= bh_d;
    if (emit) begin
      kind_q <= emit_kind;
      slot_q <= gasa_pkg::SLOT_W'(emit_slot);
      ogid_q <= emit_gid;
      ax_q   <= gasa_pkg::DIM_W'(emit_x);
      ay_q   <= gasa_pkg::DIM_W'(emit_y);
      last_q <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign slot_o         = slot_q;
  assign out_glyph_id_o = ogid_q;
  assign atlas_x_o      = ax_q;
  assign atlas_y_o      = ay_q;
  assign last_o         = last_q;

  // a flush request must not end in the place path
  a_flush_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW) |-> (req_q == gasa_pkg::REQ_PLACE))
    else $error("place path entered for a flush beat");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start work");

  // ring keeps at least one free slot after a placement
  a_ring_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLACE && out_free) |=> (oldest_q != next_q))
    else $error("ring overran its oldest entry");

  a_flush_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_kind == gasa_pkg::KIND_FLUSHED) |-> (live_q == '0))
    else $error("flush finished with live entries");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cx_q <= CW'(MAX_DIM)) && (cy_q <= CW'(MAX_DIM)))
    else $error("cursor left the atlas range");

endmodule

/* rtl/core/gasa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the ring entry store; no dependencies.
module gasa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr_i,
  input  logic [WIDTH-1:0]                wr_data_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_i,
  output logic [WIDTH-1:0]                rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // read data holds until the next read
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
